// File: hdl/afcrc_pkg.sv
// shared types, codes and helper functions for the ascii frame crc8 checker
// no dependencies; used by afcrc_line_parser and the top level
package afcrc_pkg;

  localparam int unsigned MAX_CONTENT_DEF     = 99;
  localparam int unsigned MAX_FIELD_CHARS_DEF = 9;

  localparam logic [7:0] CRC_POLY  = 8'h07;
  localparam logic [7:0] CRC_INIT  = 8'h00;
  localparam logic [7:0] CRC_MSB   = 8'h80;
  localparam logic [7:0] CH_START  = 8'h3F;  // '?'
  localparam logic [7:0] CH_COLON  = 8'h3A;  // ':'
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic [8:0] NUM_SAT   = 9'd256;
  localparam logic [8:0] NUM_MAX   = 9'd255;

  localparam int unsigned OUT_DATA_W = 24;

  typedef enum logic [1:0] {
    PH_AWAIT,
    PH_FIELD,
    PH_PAYLOAD,
    PH_BAD
  } phase_t;

  typedef enum logic [1:0] {
    NS_SKIP,
    NS_DIGITS,
    NS_STOP
  } num_state_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_START = 2'd1,
    ERR_CRC   = 2'd2
  } err_kind_t;

  typedef struct packed {
    logic       frame_ok;
    err_kind_t  error_kind;
    logic [7:0] computed_crc;
    logic [7:0] expected_crc;
    logic       expected_in_range;
  } verdict_t;

  // one byte of crc-8, msb first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_MSB) != 8'h00) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic is_space(input logic [7:0] ch);
    return ch inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= CH_ZERO) && (ch <= CH_NINE);
  endfunction

endpackage

// File: hdl/afcrc_line_parser.sv
// per-line parse state: start check, decimal field, crc over content and payload
// depends on afcrc_pkg; one byte or one line end is taken per step
module afcrc_line_parser #(
  parameter int unsigned MAX_CONTENT     = afcrc_pkg::MAX_CONTENT_DEF,
  parameter int unsigned MAX_FIELD_CHARS = afcrc_pkg::MAX_FIELD_CHARS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          step_byte,
  input  logic                step_last,
  output afcrc_pkg::verdict_t verdict
);
  import afcrc_pkg::*;

  localparam int unsigned CC_W = $clog2(MAX_CONTENT + 1);
  localparam int unsigned FC_W = $clog2(MAX_FIELD_CHARS + 2);
  localparam logic [CC_W-1:0] CC_MAX = CC_W'(MAX_CONTENT);
  localparam logic [FC_W-1:0] FC_MAX = FC_W'(MAX_FIELD_CHARS);

  phase_t          phase_r,   phase_nxt;
  logic [CC_W-1:0] cc_r,      cc_nxt;
  logic [FC_W-1:0] fc_r,      fc_nxt;
  num_state_t      ns_r,      ns_nxt;
  logic            neg_r,     neg_nxt;
  logic [8:0]      num_r,     num_nxt;
  logic [7:0]      crc_all_r, crc_all_nxt;
  logic [7:0]      crc_pl_r,  crc_pl_nxt;
  logic            colon_r,   colon_nxt;
  logic            ended_r,   ended_nxt;

  logic [7:0]  crc_all_upd;
  logic [7:0]  crc_pl_upd;
  logic [11:0] num_acc;
  logic [8:0]  num_upd;
  logic        dig;

  assign crc_all_upd = crc8_byte(crc_all_r, step_byte);
  assign crc_pl_upd  = crc8_byte(crc_pl_r, step_byte);
  assign dig         = is_digit(step_byte);
  // value*10 + digit, saturating
  assign num_acc = {num_r, 3'b000} + {2'b00, num_r, 1'b0} + {4'h0, step_byte - CH_ZERO};
  assign num_upd = (num_acc > 12'(NUM_MAX)) ? NUM_SAT : num_acc[8:0];

  // verdict from current state
  always_comb begin
    logic inr;
    logic [7:0] expv;
    logic [7:0] comp;
    inr  = 1'b0;
    expv = 8'h00;
    comp = 8'h00;
    verdict = '0;
    if (phase_r == PH_AWAIT || phase_r == PH_BAD) begin
      verdict.error_kind = ERR_START;
    end else begin
      comp = colon_r ? crc_pl_r : crc_all_r;
      inr  = 1'b1;
      if (colon_r && fc_r <= FC_MAX) begin
        if (num_r > NUM_MAX || (neg_r && num_r != 9'd0)) begin
          inr = 1'b0;
        end else begin
          expv = num_r[7:0];
        end
      end
      verdict.computed_crc      = comp;
      verdict.expected_crc      = expv;
      verdict.expected_in_range = inr;
      if (inr && expv == comp) begin
        verdict.frame_ok   = 1'b1;
        verdict.error_kind = ERR_NONE;
      end else begin
        verdict.error_kind = ERR_CRC;
      end
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    cc_nxt      = cc_r;
    fc_nxt      = fc_r;
    ns_nxt      = ns_r;
    neg_nxt     = neg_r;
    num_nxt     = num_r;
    crc_all_nxt = crc_all_r;
    crc_pl_nxt  = crc_pl_r;
    colon_nxt   = colon_r;
    ended_nxt   = ended_r;
    if (step) begin
      if (step_last) begin
        phase_nxt   = PH_AWAIT;
        cc_nxt      = '0;
        fc_nxt      = '0;
        ns_nxt      = NS_SKIP;
        neg_nxt     = 1'b0;
        num_nxt     = '0;
        crc_all_nxt = CRC_INIT;
        crc_pl_nxt  = CRC_INIT;
        colon_nxt   = 1'b0;
        ended_nxt   = 1'b0;
      end else if (!ended_r && cc_r < CC_MAX) begin
        if (step_byte == CH_NUL) begin
          ended_nxt = 1'b1;
        end else begin
          cc_nxt      = cc_r + 1'b1;
          crc_all_nxt = crc_all_upd;
          case (phase_r)
            PH_AWAIT: begin
              phase_nxt = (step_byte == CH_START) ? PH_FIELD : PH_BAD;
            end
            PH_FIELD: begin
              if (step_byte == CH_COLON) begin
                colon_nxt = 1'b1;
                phase_nxt = PH_PAYLOAD;
              end else begin
                if (fc_r <= FC_MAX) fc_nxt = fc_r + 1'b1;
                case (ns_r)
                  NS_SKIP: begin
                    if (is_space(step_byte)) begin
                      ns_nxt = NS_SKIP;
                    end else if (step_byte == CH_PLUS) begin
                      ns_nxt = NS_DIGITS;
                    end else if (step_byte == CH_MINUS) begin
                      neg_nxt = 1'b1;
                      ns_nxt  = NS_DIGITS;
                    end else if (!dig) begin
                      ns_nxt = NS_STOP;
                    end else begin
                      ns_nxt  = NS_DIGITS;
                      num_nxt = num_upd;
                    end
                  end
                  NS_DIGITS: begin
                    if (!dig) begin
                      ns_nxt = NS_STOP;
                    end else begin
                      num_nxt = num_upd;
                    end
                  end
                  default: ns_nxt = ns_r;
                endcase
              end
            end
            PH_PAYLOAD: begin
              crc_pl_nxt = crc_pl_upd;
            end
            default: phase_nxt = phase_r;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_AWAIT;
      cc_r      <= '0;
      fc_r      <= '0;
      ns_r      <= NS_SKIP;
      neg_r     <= 1'b0;
      num_r     <= '0;
      crc_all_r <= CRC_INIT;
      crc_pl_r  <= CRC_INIT;
      colon_r   <= 1'b0;
      ended_r   <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      cc_r      <= cc_nxt;
      fc_r      <= fc_nxt;
      ns_r      <= ns_nxt;
      neg_r     <= neg_nxt;
      num_r     <= num_nxt;
      crc_all_r <= crc_all_nxt;
      crc_pl_r  <= crc_pl_nxt;
      colon_r   <= colon_nxt;
      ended_r   <= ended_nxt;
    end
  end

endmodule

// File: hdl/ascii_frame_crc8_checker_unit.sv
// Checks text lines of the form '?<decimal>:<payload>' arriving one byte per word,
// with in_tlast marking the line end (the byte of that word is not part of the line).
// One verdict word leaves per line. The block takes one word every cycle unless a line
// end waits behind an untaken verdict; the path that sets this is the one-byte crc-8
// update and the decimal multiply-add in the parser. A line end passes the input register,
// then the out_tvalid register. While a verdict waits, plain bytes go on; a line end is held.
// depends on afcrc_pkg and afcrc_line_parser
module ascii_frame_crc8_checker_unit #(
  parameter int unsigned MAX_CONTENT     = afcrc_pkg::MAX_CONTENT_DEF,
  parameter int unsigned MAX_FIELD_CHARS = afcrc_pkg::MAX_FIELD_CHARS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [7:0]                           in_tdata,   // byte_value
  input  logic                                 in_tlast,   // line_end
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // frame_ok, error_kind[1:0], computed_crc[7:0], expected_crc[7:0],
  // expected_in_range, zero fill
  output logic [afcrc_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import afcrc_pkg::*;

  logic                  in_valid_r, in_valid_nxt;
  logic [7:0]            in_byte_r;
  logic                  in_last_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  advance;
  logic                  step;
  logic                  load;
  verdict_t              verdict;

  // a plain byte never waits on the output side
  assign advance   = !in_last_r || !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;
  assign step      = in_valid_r && advance;
  assign load      = step && in_last_r;

  assign in_valid_nxt  = (in_tvalid && in_tready) ? 1'b1 : (step ? 1'b0 : in_valid_r);
  assign out_valid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  afcrc_line_parser #(
    .MAX_CONTENT     (MAX_CONTENT),
    .MAX_FIELD_CHARS (MAX_FIELD_CHARS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .step_byte (in_byte_r),
    .step_last (in_last_r),
    .verdict   (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (load) begin
      out_data_r <= {4'h0, verdict.expected_in_range, verdict.expected_crc,
                     verdict.computed_crc, verdict.error_kind, verdict.frame_ok};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
